// File: rtl/isl_pkg.sv
// Shared types for the indexed shift list: command and status codes,
// and the per-cell control group. No dependencies.
`default_nettype none

package isl_pkg;

	typedef enum logic [2:0] {
		CMD_APPEND    = 3'd0,
		CMD_PREPEND   = 3'd1,
		CMD_INSERT    = 3'd2,
		CMD_TAKE      = 3'd3,
		CMD_GET       = 3'd4,
		CMD_SET       = 3'd5,
		CMD_POP_LAST  = 3'd6,
		CMD_POP_FIRST = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2,
		STATUS_EMPTY = 2'd3
	} status_t;

	// What each cell does with its word on the execute edge
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,   // cells above the gap take the lower neighbor
		CELL_REMOVE = 2'd2,   // cells at and above the gap take the upper neighbor
		CELL_WRITE  = 2'd3    // only the addressed cell loads the new word
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     rd_en;      // a word is to be read out
		logic     capture;    // leaf registers load on this edge
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/isl_cell.sv
// One list entry: holds a word, shifts to/from its neighbors, and offers
// its word to the read tree when addressed. Depends on isl_pkg.
`default_nettype none

module isl_cell
	import isl_pkg::*;
#(
	parameter int W     = 32,
	parameter int AW    = 6,
	parameter int INDEX = 0
) (
	input  wire            clk,
	input  cell_ctl_t      ctl,
	input  wire [AW-1:0]   at,
	input  wire [AW-1:0]   rd_idx,
	input  wire [W-1:0]    wr_word,
	input  wire [W-1:0]    left_word,
	input  wire [W-1:0]    right_word,
	output logic [W-1:0]   word,
	output logic [W-1:0]   leaf
);

	localparam logic [AW-1:0] IDX = AW'(INDEX);

	logic [W-1:0] word_q;
	logic [W-1:0] leaf_s1;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				if (IDX > at) begin
					word_q <= left_word;
				end else if (IDX == at) begin
					word_q <= wr_word;
				end
			end
			CELL_REMOVE: begin
				if (IDX >= at) begin
					word_q <= right_word;
				end
			end
			CELL_WRITE: begin
				if (IDX == at) begin
					word_q <= wr_word;
				end
			end
			default: begin
			end
		endcase
		// leaf samples the pre-update word
		if (ctl.capture) begin
			leaf_s1 <= (ctl.rd_en && (rd_idx == IDX)) ? word_q : '0;
		end
	end

	assign word = word_q;
	assign leaf = leaf_s1;

endmodule

`default_nettype wire

// File: rtl/isl_or_tree.sv
// Registered 8-way OR tree that merges the one-hot cell leaves into a
// single read word. Standalone; no package needed.
`default_nettype none

module isl_or_tree #(
	parameter int W = 32,
	parameter int N = 64
) (
	input  wire           clk,
	input  wire [W-1:0]   leaf [N],
	output logic [W-1:0]  root
);

	localparam int LEVELS = ($clog2(N) + 2) / 3;
	localparam int PAD    = 1 << (3 * LEVELS);
	localparam int NODES  = (PAD - 1) / 7;

	// leaves first, then each level in turn; node n has children 8n..8n+7
	logic [W-1:0] all_w  [PAD + NODES];
	logic [W-1:0] next_w [NODES];
	logic [W-1:0] node_q [NODES];

	for (genvar i = 0; i < PAD; i++) begin : g_leaf
		if (i < N) begin : g_used
			assign all_w[i] = leaf[i];
		end else begin : g_zero
			assign all_w[i] = '0;
		end
	end

	for (genvar n = 0; n < NODES; n++) begin : g_node
		assign all_w[PAD + n] = node_q[n];
	end

	always_comb begin
		for (int n = 0; n < NODES; n++) begin
			next_w[n] = '0;
			for (int c = 0; c < 8; c++) begin
				next_w[n] = next_w[n] | all_w[8 * n + c];
			end
		end
	end

	always_ff @(posedge clk) begin
		node_q <= next_w;
	end

	assign root = node_q[NODES - 1];

endmodule

`default_nettype wire

// File: rtl/indexed_shift_list_top.sv
// Indexed shift list: bounded ordered list held in a row of shifting cells,
// read out through a registered OR tree. Depends on isl_pkg, isl_cell, isl_or_tree.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+---------------------------------------------
//  s_      | in  | s_tvalid/s_tready | command[2:0] position[8:3] element[40:9]
//  m_      | out | m_tvalid/m_tready | element_out[31:0] fill_count[38:32]
//          |     |                   | status[40:39]
//
// A transaction runs as follows, with LEVELS = ceil(log2(CAPACITY)/3) tree levels:
// accept, an execute edge where every cell shifts or loads at once, then the
// read word climbs the OR tree, one level per cycle, into the output register.
// Reset clears the fill count, the state machine and the output valid; cell
// words are not reset. A stalled master side holds the finished result while
// the next transaction is taken and executed; it waits at the tree root.
`default_nettype none

module indexed_shift_list_top
	import isl_pkg::*;
#(
	parameter int CAPACITY     = 64,
	parameter int ELEMENT_BITS = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [47:0]  s_tdata,   // command[2:0], position[8:3], element[40:9], zeros
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata    // element_out[31:0], fill_count[38:32], status[40:39]
);

	localparam int W      = ELEMENT_BITS;
	localparam int AW     = $clog2(CAPACITY);
	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int XCW    = (CW > 7) ? CW : 7;       // compare width for index vs count
	localparam int XW     = (W > 32) ? W : 32;
	localparam int LEVELS = ($clog2(CAPACITY) + 2) / 3;
	localparam int LW     = $clog2(LEVELS + 1);

	localparam logic [CW-1:0] COUNT_FULL = CW'(CAPACITY);
	localparam logic [LW-1:0] WAIT_LAST  = LW'(LEVELS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WAIT
	} state_t;

	state_t        state_q;
	logic [LW-1:0] wait_q;
	logic [CW-1:0] count_q;
	logic          m_valid_q;

	// accepted command
	cmd_t          cmd_q;
	logic [5:0]    pos_q;
	logic [W-1:0]  word_q;
	status_t       status_q;

	// output register
	logic [31:0]   m_elem_q;
	logic [6:0]    m_count_q;
	status_t       m_status_q;

	// decode
	cell_op_t      op_w;
	logic [AW-1:0] at_w;
	logic [AW-1:0] rd_idx_w;
	logic          rd_en_w;
	logic [CW-1:0] count_next_w;
	status_t       status_w;
	logic [XCW-1:0] pos_x;
	logic [XCW-1:0] cnt_x;
	logic [CW-1:0] count_dec;
	logic          full_w;
	logic          empty_w;

	logic          accept_w;
	logic          capture_w;
	logic [XW-1:0] in_ext;
	logic [XW-1:0] root_ext;
	logic [XCW-1:0] count_ext;

	cell_ctl_t     ctl_w;
	logic [W-1:0]  cell_word [CAPACITY];
	logic [W-1:0]  leaf_w    [CAPACITY];
	logic [W-1:0]  root_w;

	assign accept_w  = s_tvalid && s_tready;
	assign capture_w = (state_q == ST_WAIT) && (wait_q == WAIT_LAST)
		&& (!m_valid_q || m_tready);

	assign pos_x     = XCW'(pos_q);
	assign cnt_x     = XCW'(count_q);
	assign count_dec = count_q - CW'(1);
	assign full_w    = (count_q == COUNT_FULL);
	assign empty_w   = (count_q == '0);

	// command decode against the current fill count
	always_comb begin
		op_w         = CELL_HOLD;
		at_w         = '0;
		rd_idx_w     = '0;
		rd_en_w      = 1'b0;
		count_next_w = count_q;
		status_w     = STATUS_OK;
		case (cmd_q)
			CMD_APPEND: begin
				if (full_w) begin
					status_w = STATUS_FULL;
				end else begin
					op_w         = CELL_INSERT;
					at_w         = count_q[AW-1:0];
					count_next_w = count_q + CW'(1);
				end
			end
			CMD_PREPEND: begin
				if (full_w) begin
					status_w = STATUS_FULL;
				end else begin
					op_w         = CELL_INSERT;
					count_next_w = count_q + CW'(1);
				end
			end
			CMD_INSERT: begin
				if (full_w) begin
					status_w = STATUS_FULL;
				end else if (pos_x > cnt_x) begin
					status_w = STATUS_RANGE;
				end else begin
					op_w         = CELL_INSERT;
					at_w         = pos_x[AW-1:0];
					count_next_w = count_q + CW'(1);
				end
			end
			CMD_TAKE: begin
				if (empty_w) begin
					status_w = STATUS_EMPTY;
				end else if (pos_x >= cnt_x) begin
					status_w = STATUS_RANGE;
				end else begin
					op_w         = CELL_REMOVE;
					at_w         = pos_x[AW-1:0];
					rd_idx_w     = pos_x[AW-1:0];
					rd_en_w      = 1'b1;
					count_next_w = count_dec;
				end
			end
			CMD_GET: begin
				if (pos_x >= cnt_x) begin
					status_w = STATUS_RANGE;
				end else begin
					rd_idx_w = pos_x[AW-1:0];
					rd_en_w  = 1'b1;
				end
			end
			CMD_SET: begin
				if (pos_x >= cnt_x) begin
					status_w = STATUS_RANGE;
				end else begin
					op_w     = CELL_WRITE;
					at_w     = pos_x[AW-1:0];
					rd_idx_w = pos_x[AW-1:0];
					rd_en_w  = 1'b1;
				end
			end
			CMD_POP_LAST: begin
				if (empty_w) begin
					status_w = STATUS_EMPTY;
				end else begin
					rd_idx_w     = count_dec[AW-1:0];
					rd_en_w      = 1'b1;
					count_next_w = count_dec;
				end
			end
			CMD_POP_FIRST: begin
				if (empty_w) begin
					status_w = STATUS_EMPTY;
				end else begin
					op_w         = CELL_REMOVE;
					rd_en_w      = 1'b1;
					count_next_w = count_dec;
				end
			end
			default: begin
			end
		endcase
	end

	// cells act only on the execute edge
	assign ctl_w.op      = (state_q == ST_EXEC) ? op_w : CELL_HOLD;
	assign ctl_w.rd_en   = rd_en_w;
	assign ctl_w.capture = (state_q == ST_EXEC);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [W-1:0] left_w;
		logic [W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_word[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = cell_word[i];
		end else begin : g_mid_r
			assign right_w = cell_word[i+1];
		end
		isl_cell #(
			.W     (W),
			.AW    (AW),
			.INDEX (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl_w),
			.at         (at_w),
			.rd_idx     (rd_idx_w),
			.wr_word    (word_q),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (cell_word[i]),
			.leaf       (leaf_w[i])
		);
	end

	isl_or_tree #(
		.W (W),
		.N (CAPACITY)
	) u_tree (
		.clk  (clk),
		.leaf (leaf_w),
		.root (root_w)
	);

	// control: state, fill count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wait_q    <= '0;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (capture_w) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept_w) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					count_q <= count_next_w;
					wait_q  <= '0;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (wait_q != WAIT_LAST) begin
						wait_q <= wait_q + LW'(1);
					end else if (capture_w) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ext    = XW'(s_tdata[40:9]);
	assign root_ext  = XW'(root_w);
	assign count_ext = XCW'(count_q);

	// payload registers
	always_ff @(posedge clk) begin
		if (accept_w) begin
			cmd_q  <= cmd_t'(s_tdata[2:0]);
			pos_q  <= s_tdata[8:3];
			word_q <= in_ext[W-1:0];
		end
		if (state_q == ST_EXEC) begin
			status_q <= status_w;
		end
		if (capture_w) begin
			m_elem_q   <= root_ext[31:0];
			m_count_q  <= count_ext[6:0];
			m_status_q <= status_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, m_status_q, m_count_q, m_elem_q};

	// fill count never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_FULL)
		else $error("fill count above capacity");

	// the count only moves on the execute edge
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_EXEC) |=> $stable(count_q))
		else $error("fill count changed outside execute");

	// a new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		capture_w |-> (!m_valid_q || m_tready))
		else $error("output register overwritten");

	// error results carry a zero word
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && (m_status_q != STATUS_OK)) |-> (m_elem_q == 32'd0))
		else $error("nonzero word on error result");

	// execute always leads straight into the tree wait
	a_exec_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |=> (state_q == ST_WAIT) && (wait_q == '0))
		else $error("execute did not start the read wait");

endmodule

`default_nettype wire

// File: tb/tb_indexed_shift_list_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for indexed_shift_list_top: drives list commands on the
// slave stream and checks every reply against a list predictor. Depends on isl_pkg.

import isl_pkg::*;

// One reply as the master stream carries it
typedef struct packed {
	logic [31:0] word;
	logic [6:0]  count;
	status_t     status;
} list_reply_t;

// Mirrors the list contents and queues the reply each accepted command owes
class list_scoreboard;
	localparam int SLOTS = 64;

	logic [31:0] words [SLOTS];
	int          held;
	list_reply_t replies_due [$];
	int          errors;
	int          checked;
	int          peak;
	int          fills;
	int          status_seen [4];

	function new();
		held    = 0;
		errors  = 0;
		checked = 0;
		peak    = 0;
		fills   = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
	endfunction

	// Shift entries at and above 'at' up by one and drop the word in
	function void open_slot(int at, logic [31:0] word);
		for (int i = held; i > at; i--) words[i] = words[i - 1];
		words[at] = word;
		held++;
	endfunction

	// Remove the entry at 'at' and shift the ones above it down
	function logic [31:0] close_slot(int at);
		logic [31:0] word;
		word = words[at];
		for (int i = at; i + 1 < held; i++) words[i] = words[i + 1];
		held--;
		return word;
	endfunction

	function void apply_command(cmd_t cmd, logic [5:0] pos, logic [31:0] elem);
		list_reply_t r;
		int          p;
		int          was_held;
		r.word   = '0;
		r.status = STATUS_OK;
		p        = int'(pos);
		was_held = held;
		case (cmd)
			CMD_APPEND: begin
				if (held == SLOTS) r.status = STATUS_FULL;
				else open_slot(held, elem);
			end
			CMD_PREPEND: begin
				if (held == SLOTS) r.status = STATUS_FULL;
				else open_slot(0, elem);
			end
			CMD_INSERT: begin
				// full test wins over the index test
				if (held == SLOTS) r.status = STATUS_FULL;
				else if (p > held) r.status = STATUS_RANGE;
				else open_slot(p, elem);
			end
			CMD_TAKE: begin
				if (held == 0) r.status = STATUS_EMPTY;
				else if (p >= held) r.status = STATUS_RANGE;
				else r.word = close_slot(p);
			end
			CMD_GET: begin
				if (p >= held) r.status = STATUS_RANGE;
				else r.word = words[p];
			end
			CMD_SET: begin
				if (p >= held) r.status = STATUS_RANGE;
				else begin
					r.word   = words[p];
					words[p] = elem;
				end
			end
			CMD_POP_LAST: begin
				if (held == 0) r.status = STATUS_EMPTY;
				else begin
					held--;
					r.word = words[held];
				end
			end
			default: begin
				if (held == 0) r.status = STATUS_EMPTY;
				else r.word = close_slot(0);
			end
		endcase
		r.count = held[6:0];
		if (held > peak) peak = held;
		if (held == SLOTS && was_held != SLOTS) fills++;
		status_seen[r.status]++;
		replies_due.push_back(r);
	endfunction

	function void check_reply(logic [47:0] data);
		list_reply_t want;
		checked++;
		if (replies_due.size() == 0) begin
			$error("reply with nothing outstanding: tdata %h", data);
			errors++;
			return;
		end
		want = replies_due.pop_front();
		if (data[31:0] !== want.word) begin
			$error("element_out: expected %h, got %h", want.word, data[31:0]);
			errors++;
		end
		if (data[38:32] !== want.count) begin
			$error("fill_count: expected %0d, got %0d", want.count, data[38:32]);
			errors++;
		end
		if (data[40:39] !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, data[40:39]);
			errors++;
		end
	endfunction
endclass

module tb_indexed_shift_list_top;

	localparam int CAPACITY     = 64;
	localparam int RANDOM_ITEMS = 450;
	localparam int LATENCY      = 5;        // accept, execute, two tree levels, output register
	localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
	localparam int CYCLE_LIMIT  = 250000;

	typedef enum {PH_FILL, PH_DRAIN, PH_MIXED, PH_FULL} phase_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;    // command[2:0], position[8:3], element[40:9], zeros
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;    // element_out[31:0], fill_count[38:32], status[40:39]

	list_scoreboard sb = new();

	int   cycles         = 0;
	int   sent           = 0;
	logic sender_gaps_on = 1'b1;
	logic hold_off_req   = 1'b0;
	int   holds_done     = 0;

	indexed_shift_list_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding",
				cycles, sb.replies_due.size());
			$display("FAILURE");
			$finish;
		end
	end

	// Mostly back-to-back, some short pauses, the odd long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] pick_element();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 32'h0000_0000;
		if (r == 1) return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	// Position mostly inside the legal window for the command, sometimes anywhere
	function automatic logic [5:0] pick_position(cmd_t cmd, phase_t phase);
		int top;
		if ($urandom_range(0, 99) < 20) return 6'($urandom_range(0, 63));
		if (phase == PH_FULL && $urandom_range(0, 2) == 0) return 6'd63;
		top = (cmd == CMD_INSERT) ? sb.held : sb.held - 1;
		if (top < 0) return 6'($urandom_range(0, 63));
		if (top > 63) top = 63;
		return 6'($urandom_range(0, top));
	endfunction

	function automatic cmd_t pick_command(phase_t phase);
		int r;
		r = $urandom_range(0, 99);
		if (phase == PH_FILL && r < 85) begin
			case ($urandom_range(0, 2))
				0:       return CMD_APPEND;
				1:       return CMD_PREPEND;
				default: return CMD_INSERT;
			endcase
		end
		if (phase == PH_DRAIN && r < 85) begin
			case ($urandom_range(0, 2))
				0:       return CMD_TAKE;
				1:       return CMD_POP_LAST;
				default: return CMD_POP_FIRST;
			endcase
		end
		return cmd_t'($urandom_range(0, 7));
	endfunction

	// Offer one command after an optional idle gap, hold it until accepted,
	// then let the predictor account for it. Valid stays high afterward so
	// back-to-back transactions need no extra edge.
	task automatic offer(cmd_t cmd, logic [5:0] pos, logic [31:0] elem);
		int gap;
		gap = sender_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk) s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = {7'd0, elem, pos, cmd};
		do @(posedge clk); while (!s_tready);
		sb.apply_command(cmd, pos, elem);
		sent++;
	endtask

	// Result side: every accepted reply goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_reply(m_tdata);
	end

	// Receiver ready pattern: runs of ready, random stalls, and one long
	// hold-off on request so the block backs up into its input
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_off_req) begin
				@(negedge clk) m_tready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_off_req = 1'b0;
				holds_done++;
			end else begin
				@(negedge clk) m_tready = 1'b1;
				repeat ($urandom_range(0, 24)) @(negedge clk);
				stall = pick_gap();
				if (stall > 0) begin
					@(negedge clk) m_tready = 1'b0;
					repeat (stall - 1) @(negedge clk);
				end
			end
		end
	end

	initial begin
		phase_t     phase;
		int         phase_len;
		int         random_sent;
		logic       hold_asked;
		cmd_t       cmd;

		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		random_sent = 0;
		hold_asked  = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: every error path on an empty list, then a short list
		// exercised at its edges
		offer(CMD_POP_LAST,  6'd0,  32'h0);          // pop on empty
		offer(CMD_POP_FIRST, 6'd0,  32'h0);
		offer(CMD_TAKE,      6'd0,  32'h0);          // take on empty
		offer(CMD_GET,       6'd0,  32'h0);          // get on empty: bad index
		offer(CMD_SET,       6'd63, 32'hFFFF_FFFF);  // set on empty: bad index
		offer(CMD_INSERT,    6'd1,  32'h1);          // insert past the end
		offer(CMD_INSERT,    6'd0,  32'hFFFF_FFFF);
		offer(CMD_APPEND,    6'd0,  32'h0000_0000);
		offer(CMD_PREPEND,   6'd0,  32'hAAAA_AAAA);
		offer(CMD_INSERT,    6'd3,  32'h5555_5555);  // index == count appends
		offer(CMD_INSERT,    6'd63, 32'h7);
		offer(CMD_INSERT,    6'd2,  32'h8000_0001);  // mid insert shifts up
		offer(CMD_GET,       6'd0,  32'h0);
		offer(CMD_GET,       6'd4,  32'h0);
		offer(CMD_GET,       6'd5,  32'h0);          // one past the end
		offer(CMD_SET,       6'd1,  32'h1234_5678);  // returns the old word
		offer(CMD_TAKE,      6'd1,  32'h0);          // shifts the rest down
		offer(CMD_TAKE,      6'd63, 32'h0);
		offer(CMD_POP_FIRST, 6'd0,  32'h0);          // entry 0 out, rest down
		offer(CMD_POP_LAST,  6'd0,  32'h0);
		offer(CMD_GET,       6'd0,  32'h0);
		offer(CMD_POP_LAST,  6'd0,  32'h0);
		offer(CMD_POP_LAST,  6'd0,  32'h0);
		offer(CMD_PREPEND,   6'd0,  32'hDEAD_BEEF);
		offer(CMD_POP_FIRST, 6'd0,  32'h0);

		// Random: phases that grow the list to full, hammer it while full,
		// drain it to empty, or mix everything
		while (random_sent < RANDOM_ITEMS) begin
			if (sb.held == CAPACITY)
				phase = ($urandom_range(0, 1) == 0) ? PH_FULL : PH_DRAIN;
			else if (sb.held == 0)
				phase = PH_FILL;
			else begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7: phase = PH_FILL;
					8, 9, 10, 11, 12, 13:   phase = PH_DRAIN;
					default:                phase = PH_MIXED;
				endcase
			end
			phase_len      = (phase == PH_FULL) ? $urandom_range(8, 20)
				: $urandom_range(15, 90);
			sender_gaps_on = ($urandom_range(0, 3) != 0);

			// Once, mid-run: receiver stops while the sender streams flat out
			if (!hold_asked && random_sent >= 150) begin
				hold_asked     = 1'b1;
				hold_off_req   = 1'b1;
				sender_gaps_on = 1'b0;
			end

			for (int i = 0; i < phase_len && random_sent < RANDOM_ITEMS; i++) begin
				if (phase == PH_FILL && sb.held == CAPACITY && i > 4) break;
				if (phase == PH_DRAIN && sb.held == 0 && i > 4) break;
				cmd = pick_command(phase);
				offer(cmd, pick_position(cmd, phase), pick_element());
				random_sent++;
			end
		end

		@(negedge clk) s_tvalid = 1'b0;
		while (sb.replies_due.size() != 0) @(posedge clk);
		// quiet period: anything arriving now is an extra reply
		repeat (4 * LATENCY) @(posedge clk);

		$display("%0d commands, %0d replies checked, peak fill %0d of %0d",
			sent, sb.checked, sb.peak, CAPACITY);
		$display("full %0d times, %0d long hold-off; status mix: ok %0d, full refused %0d, %s",
			sb.fills, holds_done, sb.status_seen[STATUS_OK], sb.status_seen[STATUS_FULL],
			$sformatf("bad index %0d, empty %0d",
				sb.status_seen[STATUS_RANGE], sb.status_seen[STATUS_EMPTY]));
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: sim.f
rtl/isl_pkg.sv
rtl/isl_cell.sv
rtl/isl_or_tree.sv
rtl/indexed_shift_list_top.sv
tb/tb_indexed_shift_list_top.sv
